// File: hw/rtl/pfdm_pkg.sv
// Shared constants, codes and types of the PWM frequency and duty meter.
`timescale 1ns / 1ps
`default_nettype none
package pfdm_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int TS_W           = 32;
	localparam int TPS_W          = 24;
	localparam int FIELD_W        = 32;
	localparam int DUTY_W         = 15;

	localparam logic [TPS_W-1:0]  TPS_RESET    = 24'd1000000;
	localparam logic [DUTY_W-1:0] DUTY_FULL_Q8 = 15'd25600;

	typedef enum logic [1:0] {
		CMD_RISE   = 2'd0,
		CMD_FALL   = 2'd1,
		CMD_REPORT = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AVG_GO,
		S_AVG_RUN,
		S_FREQ_GO,
		S_FREQ_RUN,
		S_DUTY_GO,
		S_DUTY_RUN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/pfdm_in_if.sv
// Input channel: edge and report words with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface pfdm_in_if;
	import pfdm_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic [TS_W-1:0]   timestamp;

	modport source (output valid, output cmd, output timestamp, input ready);
	modport sink   (input valid, input cmd, input timestamp, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pfdm_out_if.sv
// Result channel: measurement words with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface pfdm_out_if;
	import pfdm_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] frequency_q8;
	logic [DUTY_W-1:0]  duty_q8;
	logic [FIELD_W-1:0] period_ticks;
	logic [FIELD_W-1:0] high_ticks;
	logic [FIELD_W-1:0] low_ticks;

	modport source (output valid, output frequency_q8, output duty_q8, output period_ticks,
		output high_ticks, output low_ticks, input ready);
	modport sink   (input valid, input frequency_q8, input duty_q8, input period_ticks,
		input high_ticks, input low_ticks, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pfdm_cfg_if.sv
// Configuration write channel for the tick rate register.
`timescale 1ns / 1ps
`default_nettype none
interface pfdm_cfg_if;
	import pfdm_pkg::*;

	logic             valid;
	logic             ready;
	logic [TPS_W-1:0] ticks_per_second;

	modport source (output valid, output ticks_per_second, input ready);
	modport sink   (input valid, input ticks_per_second, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pfdm_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pfdm_div #(
	parameter int NW = 47,
	parameter int DW = 32,
	parameter int CW = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NW-1:0]     num,
	input  wire logic [DW-1:0]     den,
	input  wire logic [CW-1:0]     steps,
	output pfdm_pkg::div_stat_t    stat,
	output logic [NW-1:0]          quot
);
	import pfdm_pkg::*;

	logic [NW-1:0] num_q;
	logic [NW-1:0] quot_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   rem_sh;
	logic [DW+1:0] diff;
	logic          ge;

	// The remainder stays below the divisor, so the shifted value fits in DW+1 bits.
	assign rem_sh = {rem_q[DW-1:0], num_q[NW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge     = ~diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= num_q << 1;
			rem_q  <= ge ? diff[DW:0] : rem_sh;
			quot_q <= {quot_q[NW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("divider busy with no steps left");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without running");
endmodule
`default_nettype wire

// File: hw/rtl/pwm_frequency_duty_meter.sv
// Top level of the PWM frequency and duty meter.
// Usage:
// The item channel carries words of cmd and timestamp: a rising edge, a falling
// edge, or a report request. Edge words update the stored rise and fall times,
// the high, low and period times, and the period sum and count.
// A report word, once a full period has been seen since the last report, yields
// one word on the result channel; otherwise it is dropped and changes nothing.
// A report runs three divisions in turn on one shared divider that produces one
// quotient bit per cycle: the average period (TIME_WIDTH steps), the frequency
// (32 steps) and the duty cycle (TIME_WIDTH + 15 steps). A division with a zero
// divisor or a saturated duty is skipped. The item channel is not ready during a
// report until its result is placed in the output register. The output register
// holds one result; edge words keep being accepted while it waits, and a report
// that finishes while it is still full waits for it to drain. The cfg channel is
// always ready and writes ticks_per_second; write it only while the block is idle.
// Reset clears all measurements and sets the tick rate to 1 MHz.
`timescale 1ns / 1ps
`default_nettype none
module pwm_frequency_duty_meter #(
	parameter int TIME_WIDTH = pfdm_pkg::TIME_WIDTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pfdm_in_if.sink     item,
	pfdm_out_if.source  result,
	pfdm_cfg_if.sink    cfg
);
	import pfdm_pkg::*;

	localparam int TW = TIME_WIDTH;
	localparam int DW = (TW > 32) ? TW : 32;
	localparam int NW = ((TW + 15) > 32) ? (TW + 15) : 32;
	localparam int CW = $clog2(NW + 1);

	state_t state_q, state_d;

	logic [TPS_W-1:0]  tps_q;
	logic [TW-1:0]     last_rise_q, last_fall_q;
	logic              rise_seen_q, fall_seen_q;
	logic [TW-1:0]     high_q, low_q, period_q, sum_q;
	logic [31:0]       count_q;
	logic              cycle_done_q;
	logic [TW-1:0]     avg_q;
	logic [31:0]       freq_q;
	logic [DUTY_W-1:0] duty_q;

	logic               out_valid_q;
	logic [FIELD_W-1:0] out_freq_q, out_period_q, out_high_q, out_low_q;
	logic [DUTY_W-1:0]  out_duty_q;

	logic              in_acc;
	logic [TW-1:0]     ts_w, rise_diff, fall_diff;
	logic [TW+14:0]    high_x;
	logic              load_out;

	logic              div_start;
	logic [NW-1:0]     div_num;
	logic [DW-1:0]     div_den;
	logic [CW-1:0]     div_steps;
	div_stat_t         div_stat;
	logic [NW-1:0]     div_quot;

	assign item.ready = (state_q == S_IDLE);
	assign in_acc     = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	assign ts_w      = TW'(item.timestamp);
	assign rise_diff = ts_w - last_rise_q;
	assign fall_diff = ts_w - last_fall_q;

	// 25600 = 2^14 + 2^13 + 2^10
	assign high_x = ((TW+15)'(high_q) << 14) + ((TW+15)'(high_q) << 13)
		+ ((TW+15)'(high_q) << 10);

	assign load_out = (state_q == S_DONE) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg.valid) begin
			tps_q <= cfg.ticks_per_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = NW'(sum_q) << (NW - TW);
		div_den   = DW'(count_q);
		div_steps = CW'(TW);
		case (state_q)
			S_IDLE: begin
				if (in_acc && item.cmd == CMD_REPORT && cycle_done_q) begin
					state_d = S_AVG_GO;
				end
			end
			S_AVG_GO: begin
				if (count_q != '0) begin
					div_start = 1'b1;
					state_d   = S_AVG_RUN;
				end else begin
					state_d = S_FREQ_GO;
				end
			end
			S_AVG_RUN: begin
				if (div_stat.done) begin
					state_d = S_FREQ_GO;
				end
			end
			S_FREQ_GO: begin
				div_num   = NW'({tps_q, 8'h00}) << (NW - 32);
				div_den   = DW'(avg_q);
				div_steps = CW'(32);
				if (avg_q != '0) begin
					div_start = 1'b1;
					state_d   = S_FREQ_RUN;
				end else begin
					state_d = S_DUTY_GO;
				end
			end
			S_FREQ_RUN: begin
				if (div_stat.done) begin
					state_d = S_DUTY_GO;
				end
			end
			S_DUTY_GO: begin
				div_num   = NW'(high_x) << (NW - (TW + 15));
				div_den   = DW'(period_q);
				div_steps = CW'(TW + 15);
				if (period_q != '0 && high_q < period_q) begin
					div_start = 1'b1;
					state_d   = S_DUTY_RUN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DUTY_RUN: begin
				if (div_stat.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Results of the three division phases.
	always_ff @(posedge clk) begin
		case (state_q)
			S_AVG_GO: begin
				if (count_q == '0) avg_q <= '0;
			end
			S_AVG_RUN: begin
				if (div_stat.done) avg_q <= div_quot[TW-1:0];
			end
			S_FREQ_GO: begin
				if (avg_q == '0) freq_q <= '0;
			end
			S_FREQ_RUN: begin
				if (div_stat.done) freq_q <= div_quot[31:0];
			end
			S_DUTY_GO: begin
				if (period_q == '0) begin
					duty_q <= '0;
				end else if (high_q >= period_q) begin
					duty_q <= DUTY_FULL_Q8;
				end
			end
			S_DUTY_RUN: begin
				if (div_stat.done) duty_q <= div_quot[DUTY_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_rise_q  <= '0;
			last_fall_q  <= '0;
			rise_seen_q  <= 1'b0;
			fall_seen_q  <= 1'b0;
			high_q       <= '0;
			low_q        <= '0;
			period_q     <= '0;
			sum_q        <= '0;
			count_q      <= '0;
			cycle_done_q <= 1'b0;
		end else if (in_acc) begin
			case (item.cmd)
				CMD_RISE: begin
					if (fall_seen_q) low_q <= fall_diff;
					if (rise_seen_q) begin
						period_q     <= rise_diff;
						sum_q        <= sum_q + rise_diff;
						count_q      <= count_q + 1'b1;
						cycle_done_q <= 1'b1;
					end
					last_rise_q <= ts_w;
					rise_seen_q <= 1'b1;
				end
				CMD_FALL: begin
					if (rise_seen_q) high_q <= rise_diff;
					last_fall_q <= ts_w;
					fall_seen_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end else if (load_out) begin
			sum_q        <= '0;
			count_q      <= '0;
			cycle_done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_freq_q   <= freq_q;
			out_duty_q   <= duty_q;
			out_period_q <= FIELD_W'(period_q);
			out_high_q   <= FIELD_W'(high_q);
			out_low_q    <= FIELD_W'(low_q);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.frequency_q8 = out_freq_q;
	assign result.duty_q8      = out_duty_q;
	assign result.period_ticks = out_period_q;
	assign result.high_ticks   = out_high_q;
	assign result.low_ticks    = out_low_q;

	pfdm_div #(
		.NW (NW),
		.DW (DW),
		.CW (CW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_AVG_RUN || state_q == S_FREQ_RUN
			|| state_q == S_DUTY_RUN)) else $error("division finished outside a run phase");
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_duty_q <= DUTY_FULL_Q8) else $error("duty above full scale");
	a_clear_totals: assert property (@(posedge clk) disable iff (!arst_n)
		!cycle_done_q |-> (sum_q == '0 && count_q == '0))
		else $error("period totals set with no completed cycle");
endmodule
`default_nettype wire

// File: test/tb.sv
// Testbench for the PWM frequency and duty meter: directed cases, then random edge traffic.
`timescale 1ns / 1ps
module tb;
	import pfdm_pkg::*;

	localparam logic [1:0]       CMD_UNUSED   = 2'd3;
	localparam logic [TPS_W-1:0] TPS_MIN      = 24'd1;
	localparam logic [TPS_W-1:0] TPS_MAX      = {TPS_W{1'b1}};
	localparam int               DRAIN_CYCLES = 150;
	localparam int               PHASE_WORDS  = 280;

	typedef struct packed {
		logic [FIELD_W-1:0] frequency_q8;
		logic [DUTY_W-1:0]  duty_q8;
		logic [FIELD_W-1:0] period_ticks;
		logic [FIELD_W-1:0] high_ticks;
		logic [FIELD_W-1:0] low_ticks;
	} meas_t;

	logic clk;
	logic arst_n;

	pfdm_in_if  item_ch ();
	pfdm_out_if res_ch ();
	pfdm_cfg_if cfg_ch ();

	pwm_frequency_duty_meter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the meter state.
	logic [TPS_W-1:0] tick_rate;
	logic [TS_W-1:0]  rise_time;
	logic [TS_W-1:0]  fall_time;
	logic             have_rise;
	logic             have_fall;
	logic [TS_W-1:0]  shadow_high;
	logic [TS_W-1:0]  shadow_low;
	logic [TS_W-1:0]  period;
	logic [TS_W-1:0]  period_total;
	logic [31:0]      period_tally;
	logic             cycle_ready;

	meas_t       pending_meas[$];
	int unsigned mismatches;
	bit          quiet;
	int unsigned hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb: FAIL");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic meas_t build_report();
		meas_t            m;
		logic [31:0]      avg;
		longint unsigned  scaled;
		avg = (period_tally != 0) ? period_total / period_tally : 32'd0;
		m.frequency_q8 = (avg != 0) ? {tick_rate, 8'h00} / avg : 32'd0;
		if (period == 0) begin
			m.duty_q8 = '0;
		end else if (shadow_high >= period) begin
			m.duty_q8 = DUTY_FULL_Q8;
		end else begin
			scaled = (64'(shadow_high) * 64'(DUTY_FULL_Q8)) / 64'(period);
			m.duty_q8 = scaled[DUTY_W-1:0];
		end
		m.period_ticks = period;
		m.high_ticks   = shadow_high;
		m.low_ticks    = shadow_low;
		return m;
	endfunction

	// Applies one accepted word to the shadow state and queues any result it causes.
	task automatic track_word(input logic [1:0] c, input logic [TS_W-1:0] ts);
		case (c)
			CMD_RISE: begin
				if (have_fall)
					shadow_low = ts - fall_time;
				if (have_rise) begin
					period       = ts - rise_time;
					period_total = period_total + period;
					period_tally = period_tally + 1;
					cycle_ready  = 1'b1;
				end
				rise_time = ts;
				have_rise = 1'b1;
			end
			CMD_FALL: begin
				if (have_rise)
					shadow_high = ts - rise_time;
				fall_time = ts;
				have_fall = 1'b1;
			end
			CMD_REPORT: begin
				if (cycle_ready) begin
					pending_meas.push_back(build_report());
					period_total = '0;
					period_tally = '0;
					cycle_ready  = 1'b0;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_word(input logic [1:0] c, input logic [TS_W-1:0] ts);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			item_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_ch.valid     = 1'b1;
		item_ch.cmd       = c;
		item_ch.timestamp = ts;
		do @(posedge clk); while (!item_ch.ready);
		track_word(c, ts);
	endtask

	// Drops valid, waits for every expected result, then waits a further drain time.
	task automatic wait_idle();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (pending_meas.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(input logic [TPS_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_ch.valid            = 1'b1;
		cfg_ch.ticks_per_second = v;
		do @(posedge clk); while (!cfg_ch.ready);
		tick_rate = v;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic test_early_events();
		send_word(CMD_REPORT, 32'd0);
		send_word(CMD_UNUSED, 32'd77);
		send_word(CMD_FALL, 32'd100);
		send_word(CMD_RISE, 32'd200);
		send_word(CMD_REPORT, 32'd0);
		send_word(CMD_FALL, 32'd250);
		send_word(CMD_RISE, 32'd1200);
		send_word(CMD_REPORT, 32'd0);
	endtask

	// The fall lands after the period it is compared with, so the duty clips.
	task automatic test_duty_saturation();
		send_word(CMD_RISE, 32'd1300);
		send_word(CMD_FALL, 32'd1700);
		send_word(CMD_REPORT, 32'd0);
	endtask

	task automatic test_counter_wrap();
		send_word(CMD_RISE, 32'hFFFF_FF00);
		send_word(CMD_FALL, 32'h0000_0010);
		send_word(CMD_RISE, 32'h0000_0100);
		send_word(CMD_REPORT, 32'd0);
	endtask

	task automatic test_zero_period();
		send_word(CMD_RISE, 32'd5000);
		send_word(CMD_REPORT, 32'd0);
		send_word(CMD_RISE, 32'd5000);
		send_word(CMD_REPORT, 32'd0);
	endtask

	task automatic test_extreme_times();
		send_word(CMD_RISE, 32'h0000_0000);
		send_word(CMD_RISE, 32'hFFFF_FFFF);
		send_word(CMD_FALL, 32'hFFFF_FFFF);
		send_word(CMD_REPORT, 32'd0);
	endtask

	task automatic test_rate_extremes();
		write_rate(TPS_MIN);
		send_word(CMD_RISE, 32'd99);
		send_word(CMD_REPORT, 32'd0);
		write_rate(TPS_MAX);
		send_word(CMD_RISE, 32'd100);
		send_word(CMD_RISE, 32'd108);
		send_word(CMD_REPORT, 32'd0);
	endtask

	function automatic logic [TS_W-1:0] pick_period();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2000);
		if (r < 90)
			return $urandom_range(2001, 1 << 20);
		return $urandom;
	endfunction

	// Mostly whole PWM bursts ending in a report, with some stray or broken words.
	task automatic test_random_traffic(input logic [TPS_W-1:0] rate, input int unsigned count);
		int unsigned      sent;
		int unsigned      cycles;
		logic [TS_W-1:0]  base;
		logic [TS_W-1:0]  per;
		logic [TS_W-1:0]  hi;
		write_rate(rate);
		sent  = 0;
		quiet = 1'b1;
		while (sent < count) begin
			if (sent >= 60)
				quiet = 1'b0;
			if ($urandom_range(0, 9) == 0) begin
				send_word(2'($urandom_range(0, 3)), $urandom);
				sent++;
			end else begin
				base   = $urandom;
				cycles = $urandom_range(1, 5);
				repeat (cycles) begin
					per = pick_period();
					if ($urandom_range(0, 9) == 0)
						hi = per + $urandom_range(0, 50);
					else
						hi = $urandom_range(0, per);
					send_word(CMD_RISE, base);
					sent++;
					if ($urandom_range(0, 7) != 0) begin
						send_word(CMD_FALL, base + hi);
						sent++;
					end
					base = base + per;
				end
				if ($urandom_range(0, 5) != 0) begin
					send_word(CMD_RISE, base);
					sent++;
				end
				send_word(CMD_REPORT, $urandom);
				sent++;
			end
		end
		quiet = 1'b0;
	endtask

	// Result side: random backpressure on the output word.
	initial begin
		res_ch.ready = 1'b0;
		hold_left    = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				res_ch.ready = 1'b0;
				hold_left--;
			end else begin
				res_ch.ready = 1'b1;
				hold_left    = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		meas_t got;
		meas_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.frequency_q8, res_ch.duty_q8, res_ch.period_ticks,
				res_ch.high_ticks, res_ch.low_ticks};
			if (pending_meas.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected result freq=%0d duty=%0d per=%0d hi=%0d lo=%0d",
						got.frequency_q8, got.duty_q8, got.period_ticks, got.high_ticks,
						got.low_ticks);
			end else begin
				want = pending_meas.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("tb: mismatch at %0t", $realtime);
						$display("  expected freq=%0d duty=%0d per=%0d hi=%0d lo=%0d",
							want.frequency_q8, want.duty_q8, want.period_ticks,
							want.high_ticks, want.low_ticks);
						$display("  actual   freq=%0d duty=%0d per=%0d hi=%0d lo=%0d",
							got.frequency_q8, got.duty_q8, got.period_ticks,
							got.high_ticks, got.low_ticks);
					end
				end
			end
		end
	end

	initial begin
		arst_n                  = 1'b0;
		item_ch.valid           = 1'b0;
		item_ch.cmd             = CMD_RISE;
		item_ch.timestamp       = '0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.ticks_per_second = '0;
		mismatches              = 0;
		quiet                   = 1'b0;
		tick_rate               = TPS_RESET;
		rise_time               = '0;
		fall_time               = '0;
		have_rise               = 1'b0;
		have_fall               = 1'b0;
		shadow_high             = '0;
		shadow_low              = '0;
		period                  = '0;
		period_total            = '0;
		period_tally            = '0;
		cycle_ready             = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_early_events();
		test_duty_saturation();
		test_counter_wrap();
		test_zero_period();
		test_extreme_times();
		test_rate_extremes();
		test_random_traffic(TPS_MAX, PHASE_WORDS);
		test_random_traffic(TPS_MIN, PHASE_WORDS);
		test_random_traffic(TPS_W'($urandom_range(1, 24'hFF_FFFF)), PHASE_WORDS);
		test_random_traffic(TPS_RESET, PHASE_WORDS);

		wait_idle();
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// File: pwm_frequency_duty_meter.f
hw/rtl/pfdm_pkg.sv
hw/rtl/pfdm_in_if.sv
hw/rtl/pfdm_out_if.sv
hw/rtl/pfdm_cfg_if.sv
hw/rtl/pfdm_div.sv
hw/rtl/pwm_frequency_duty_meter.sv
test/tb.sv
